@@ rtl/fbm_pkg.sv @@
// fbm_pkg: word types, command and status codes, and allocator handshake structs
// shared by every module of the file block map allocator. No dependencies.
`timescale 1ns / 1ps

package fbm_pkg;

	// command codes
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_FREE   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_UNMAPPED = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	// configuration register indexes
	localparam logic CFG_DATA_FIRST = 1'b0;
	localparam logic CFG_DATA_END   = 1'b1;

	// free bitmap word layout
	localparam int WORD_BITS = 16;
	localparam int WORD_SEL  = 4;

	typedef struct packed {
		logic [1:0] command;
		logic [6:0] file_slot;
		logic [8:0] logical_block;
	} cmd_word_t;

	typedef struct packed {
		logic [11:0] physical_block;
		logic [1:0]  status;
		logic [8:0]  freed_count;
	} rsp_word_t;

	// requests to the bitmap allocator
	typedef struct packed {
		logic alloc;
		logic rel;
	} alloc_req_t;

	// allocator status back to the sequencer
	typedef struct packed {
		logic ready;
		logic done;
	} alloc_rsp_t;

endpackage

@@ rtl/fbm_alloc.sv @@
// fbm_alloc: free-block bitmap held in 16-bit words, with a word-at-a-time scan
// for the lowest free block in the window and single-block release. Uses fbm_pkg.
`timescale 1ns / 1ps

module fbm_alloc #(
	parameter int DISK_BLOCKS = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [11:0]                      data_first,
	input  logic [12:0]                      data_end,
	input  fbm_pkg::alloc_req_t              req,
	input  logic [$clog2(DISK_BLOCKS)-1:0]   rel_blk,
	output fbm_pkg::alloc_rsp_t              rsp,
	output logic [$clog2(DISK_BLOCKS)-1:0]   blk
);

	localparam int BA = $clog2(DISK_BLOCKS);
	localparam int WB = fbm_pkg::WORD_BITS;
	localparam int NW = DISK_BLOCKS / WB;
	localparam int WA = (NW > 1) ? $clog2(NW) : 1;
	localparam int EW = (BA + 1 > 13) ? BA + 1 : 13;

	typedef enum logic [5:0] {
		A_CLR  = 6'b000001,
		A_IDLE = 6'b000010,
		A_RD   = 6'b000100,
		A_CHK  = 6'b001000,
		A_RRD  = 6'b010000,
		A_RWR  = 6'b100000
	} astate_t;

	astate_t          state_q;
	logic [WB-1:0]    mem [NW];
	logic [WB-1:0]    rdata_q;
	logic [WA-1:0]    addr_q;
	logic [3:0]       bit_q;
	logic             done_q;
	logic [BA-1:0]    blk_q;

	logic [EW-1:0]    lo_w;
	logic [EW-1:0]    hi_w;
	logic             empty;
	logic [WB-1:0]    avail;
	logic             any;
	logic [3:0]       pick;
	logic             last_word;
	logic             mem_we;
	logic [WB-1:0]    mem_wd;
	logic [EW-1:0]    base;

	// allocation window, block 0 excluded
	always_comb begin
		lo_w  = (data_first == 12'd0) ? EW'(1) : EW'(data_first);
		hi_w  = (EW'(data_end) > EW'(DISK_BLOCKS)) ? EW'(DISK_BLOCKS) : EW'(data_end);
		empty = lo_w >= hi_w;
	end

	// free bits of the current word inside the window, lowest wins
	always_comb begin
		base = EW'(addr_q) << fbm_pkg::WORD_SEL;
		for (int i = 0; i < WB; i++) begin
			avail[i] = !rdata_q[i] && ((base | EW'(i)) >= lo_w) && ((base | EW'(i)) < hi_w);
		end
		any  = |avail;
		pick = 4'd0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pick = 4'(i);
			end
		end
		last_word = ((EW'(addr_q) + EW'(1)) << fbm_pkg::WORD_SEL) >= hi_w;
	end

	// bitmap write data
	always_comb begin
		mem_we = 1'b0;
		mem_wd = '0;
		case (state_q)
			A_CLR: begin
				mem_we = 1'b1;
			end
			A_CHK: begin
				mem_we = any;
				mem_wd = rdata_q | (WB'(1) << pick);
			end
			A_RWR: begin
				mem_we = 1'b1;
				mem_wd = rdata_q & ~(WB'(1) << bit_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wd;
		end
		rdata_q <= mem[addr_q];
	end

	// scan and release sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_CLR;
			addr_q  <= '0;
			bit_q   <= '0;
			done_q  <= 1'b0;
			blk_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_CLR: begin
					if (addr_q == WA'(NW - 1)) begin
						state_q <= A_IDLE;
					end else begin
						addr_q <= addr_q + WA'(1);
					end
				end
				A_IDLE: begin
					if (req.alloc) begin
						if (empty) begin
							done_q <= 1'b1;
							blk_q  <= '0;
						end else begin
							addr_q  <= WA'(lo_w >> fbm_pkg::WORD_SEL);
							state_q <= A_RD;
						end
					end else if (req.rel) begin
						addr_q  <= WA'(rel_blk >> fbm_pkg::WORD_SEL);
						bit_q   <= rel_blk[3:0];
						state_q <= A_RRD;
					end
				end
				A_RD: begin
					state_q <= A_CHK;
				end
				A_CHK: begin
					if (any) begin
						done_q  <= 1'b1;
						blk_q   <= BA'(base | EW'(pick));
						state_q <= A_IDLE;
					end else if (last_word) begin
						done_q  <= 1'b1;
						blk_q   <= '0;
						state_q <= A_IDLE;
					end else begin
						addr_q  <= addr_q + WA'(1);
						state_q <= A_RD;
					end
				end
				A_RRD: begin
					state_q <= A_RWR;
				end
				A_RWR: begin
					done_q  <= 1'b1;
					blk_q   <= '0;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.ready = (state_q == A_IDLE);
	assign rsp.done  = done_q;
	assign blk       = blk_q;

	// a handed-out block lies inside the window
	a_blk_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && blk_q != '0) |-> (EW'(blk_q) >= lo_w && EW'(blk_q) < hi_w))
		else $error("allocated block outside window");

	// requests only reach an idle allocator
	a_req_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.alloc || req.rel) |-> state_q == A_IDLE)
		else $error("allocator request while busy");

endmodule

@@ rtl/fbm_ctrl.sv @@
// fbm_ctrl: command sequencer with the direct, indirect-home and indirect pointer
// memories; drives fbm_alloc for allocation and release. Uses fbm_pkg.
`timescale 1ns / 1ps

module fbm_ctrl #(
	parameter int FILES         = 128,
	parameter int DIRECT_PTRS   = 12,
	parameter int INDIRECT_PTRS = 256,
	parameter int DISK_BLOCKS   = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_stall,
	input  fbm_pkg::cmd_word_t               cmd_word,
	output logic                             res_valid,
	input  logic                             res_ready,
	output fbm_pkg::rsp_word_t               res_word,
	output fbm_pkg::alloc_req_t              areq,
	input  fbm_pkg::alloc_rsp_t              arsp,
	input  logic [$clog2(DISK_BLOCKS)-1:0]   ablk,
	output logic [$clog2(DISK_BLOCKS)-1:0]   rel_blk
);

	localparam int PW   = $clog2(DISK_BLOCKS);
	localparam int DD   = FILES * DIRECT_PTRS;
	localparam int ID   = FILES * INDIRECT_PTRS;
	localparam int HD   = FILES;
	localparam int DAW  = (DD > 1) ? $clog2(DD) : 1;
	localparam int IAW  = (ID > 1) ? $clog2(ID) : 1;
	localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
	localparam int MAXD = (DD > ID) ? DD : ID;
	localparam int CLW  = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam int MAXP = (DIRECT_PTRS > INDIRECT_PTRS) ? DIRECT_PTRS : INDIRECT_PTRS;
	localparam int IXW  = $clog2(MAXP + 1);
	localparam int FCW  = $clog2(DIRECT_PTRS + INDIRECT_PTRS + 2);

	typedef enum logic [14:0] {
		C_CLR    = 15'b000000000000001,
		C_IDLE   = 15'b000000000000010,
		C_LRD    = 15'b000000000000100,
		C_LOOK   = 15'b000000000001000,
		C_HALLOC = 15'b000000000010000,
		C_DALLOC = 15'b000000000100000,
		C_FDRD   = 15'b000000001000000,
		C_FDCHK  = 15'b000000010000000,
		C_FHRD   = 15'b000000100000000,
		C_FHCHK  = 15'b000001000000000,
		C_FIRD   = 15'b000010000000000,
		C_FICHK  = 15'b000100000000000,
		C_FHREL  = 15'b001000000000000,
		C_FICLR  = 15'b010000000000000,
		C_RWAIT  = 15'b100000000000000
	} cstate_t;

	cstate_t              state_q;
	cstate_t              ret_q;
	logic                 res_pend_q;
	fbm_pkg::rsp_word_t   res_q;
	logic [CLW-1:0]       clr_q;
	logic [1:0]           cmd_q;
	logic [6:0]           slot_q;
	logic [8:0]           lb_q;
	logic [IXW-1:0]       idx_q;
	logic [FCW-1:0]       freed_q;

	logic [PW-1:0]        dmem [DD];
	logic [PW-1:0]        hmem [HD];
	logic [PW-1:0]        imem [ID];
	logic [PW-1:0]        d_rd_q;
	logic [PW-1:0]        h_rd_q;
	logic [PW-1:0]        i_rd_q;

	logic [DAW-1:0]       d_addr;
	logic [IAW-1:0]       i_addr;
	logic [HAW-1:0]       h_addr;
	logic                 d_we;
	logic                 h_we;
	logic                 i_we;
	logic [PW-1:0]        d_wd;
	logic [PW-1:0]        h_wd;
	logic [PW-1:0]        i_wd;
	logic                 freeing;
	logic                 is_dir;
	logic                 is_wr;
	logic [PW-1:0]        entry;
	logic                 no_table;
	logic                 got_blk;
	logic                 accept;
	logic                 in_range_bad;
	logic                 lb_bad;
	logic                 d_last;
	logic                 i_last;

	assign accept       = cmd_valid && !cmd_stall;
	assign cmd_stall    = !(state_q == C_IDLE && !res_pend_q && arsp.ready);
	assign in_range_bad = (cmd_word.command == fbm_pkg::CMD_UNUSED) ||
		(int'(cmd_word.file_slot) >= FILES);
	assign lb_bad       = int'(cmd_word.logical_block) >= DIRECT_PTRS + INDIRECT_PTRS;

	// lookup decode
	always_comb begin
		freeing  = (cmd_q == fbm_pkg::CMD_FREE);
		is_dir   = int'(lb_q) < DIRECT_PTRS;
		is_wr    = (cmd_q == fbm_pkg::CMD_WRITE);
		entry    = is_dir ? d_rd_q : i_rd_q;
		no_table = !is_dir && (h_rd_q == '0);
		got_blk  = arsp.done && (ablk != '0);
		d_last   = idx_q == IXW'(DIRECT_PTRS - 1);
		i_last   = idx_q == IXW'(INDIRECT_PTRS - 1);
	end

	// memory addresses
	always_comb begin
		if (state_q == C_CLR) begin
			d_addr = clr_q[DAW-1:0];
			i_addr = clr_q[IAW-1:0];
			h_addr = clr_q[HAW-1:0];
		end else begin
			d_addr = DAW'(int'(slot_q) * DIRECT_PTRS + (freeing ? int'(idx_q) : int'(lb_q)));
			i_addr = IAW'(int'(slot_q) * INDIRECT_PTRS +
				(freeing ? int'(idx_q) : int'(lb_q) - DIRECT_PTRS));
			h_addr = HAW'(slot_q);
		end
	end

	// memory write ports
	always_comb begin
		d_we = ((state_q == C_CLR) && ({1'b0, clr_q} < (CLW + 1)'(DD))) ||
			(state_q == C_FDCHK) ||
			((state_q == C_DALLOC) && got_blk && is_dir);
		h_we = ((state_q == C_CLR) && ({1'b0, clr_q} < (CLW + 1)'(HD))) ||
			(state_q == C_FICLR) ||
			((state_q == C_HALLOC) && got_blk);
		i_we = ((state_q == C_CLR) && ({1'b0, clr_q} < (CLW + 1)'(ID))) ||
			(state_q == C_FICLR) ||
			((state_q == C_DALLOC) && got_blk && !is_dir);
		d_wd = (state_q == C_DALLOC) ? ablk : '0;
		h_wd = (state_q == C_HALLOC) ? ablk : '0;
		i_wd = (state_q == C_DALLOC) ? ablk : '0;
	end

	// pointer memories
	always_ff @(posedge clk) begin
		if (d_we) begin
			dmem[d_addr] <= d_wd;
		end
		if (h_we) begin
			hmem[h_addr] <= h_wd;
		end
		if (i_we) begin
			imem[i_addr] <= i_wd;
		end
		d_rd_q <= dmem[d_addr];
		h_rd_q <= hmem[h_addr];
		i_rd_q <= imem[i_addr];
	end

	// allocator requests
	always_comb begin
		areq.alloc = ((state_q == C_LOOK) && is_wr &&
				(no_table || entry == '0)) ||
			((state_q == C_HALLOC) && got_blk);
		areq.rel   = ((state_q == C_FDCHK) && d_rd_q != '0) ||
			((state_q == C_FICHK) && i_rd_q != '0) ||
			(state_q == C_FHREL);
		case (state_q)
			C_FDCHK: rel_blk = d_rd_q;
			C_FICHK: rel_blk = i_rd_q;
			default: rel_blk = h_rd_q;
		endcase
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= C_CLR;
			ret_q      <= C_IDLE;
			res_pend_q <= 1'b0;
			res_q      <= '0;
			clr_q      <= '0;
			idx_q      <= '0;
			freed_q    <= '0;
			cmd_q      <= '0;
			slot_q     <= '0;
			lb_q       <= '0;
		end else begin
			if (res_pend_q && res_ready) begin
				res_pend_q <= 1'b0;
			end
			case (state_q)
				C_CLR: begin
					if (clr_q == CLW'(MAXD - 1)) begin
						state_q <= C_IDLE;
					end else begin
						clr_q <= clr_q + CLW'(1);
					end
				end
				C_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd_word.command;
						slot_q  <= cmd_word.file_slot;
						lb_q    <= cmd_word.logical_block;
						idx_q   <= '0;
						freed_q <= '0;
						if (in_range_bad) begin
							res_q      <= '{12'd0, fbm_pkg::ST_RANGE, 9'd0};
							res_pend_q <= 1'b1;
						end else if (cmd_word.command == fbm_pkg::CMD_FREE) begin
							state_q <= C_FDRD;
						end else if (lb_bad) begin
							res_q      <= '{12'd0, fbm_pkg::ST_RANGE, 9'd0};
							res_pend_q <= 1'b1;
						end else begin
							state_q <= C_LRD;
						end
					end
				end
				C_LRD: begin
					state_q <= C_LOOK;
				end
				C_LOOK: begin
					if (no_table) begin
						if (is_wr) begin
							state_q <= C_HALLOC;
						end else begin
							res_q      <= '{12'd0, fbm_pkg::ST_UNMAPPED, 9'd0};
							res_pend_q <= 1'b1;
							state_q    <= C_IDLE;
						end
					end else if (entry != '0) begin
						res_q      <= '{12'(entry), fbm_pkg::ST_OK, 9'd0};
						res_pend_q <= 1'b1;
						state_q    <= C_IDLE;
					end else if (is_wr) begin
						state_q <= C_DALLOC;
					end else begin
						res_q      <= '{12'd0, fbm_pkg::ST_UNMAPPED, 9'd0};
						res_pend_q <= 1'b1;
						state_q    <= C_IDLE;
					end
				end
				C_HALLOC: begin
					if (arsp.done) begin
						if (ablk == '0) begin
							res_q      <= '{12'd0, fbm_pkg::ST_FULL, 9'd0};
							res_pend_q <= 1'b1;
							state_q    <= C_IDLE;
						end else begin
							state_q <= C_DALLOC;
						end
					end
				end
				C_DALLOC: begin
					if (arsp.done) begin
						if (ablk == '0) begin
							res_q <= '{12'd0, fbm_pkg::ST_FULL, 9'd0};
						end else begin
							res_q <= '{12'(ablk), fbm_pkg::ST_OK, 9'd0};
						end
						res_pend_q <= 1'b1;
						state_q    <= C_IDLE;
					end
				end
				C_FDRD: begin
					state_q <= C_FDCHK;
				end
				C_FDCHK: begin
					if (d_last) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + IXW'(1);
					end
					if (d_rd_q != '0) begin
						freed_q <= freed_q + FCW'(1);
						ret_q   <= d_last ? C_FHRD : C_FDRD;
						state_q <= C_RWAIT;
					end else begin
						state_q <= d_last ? C_FHRD : C_FDRD;
					end
				end
				C_FHRD: begin
					state_q <= C_FHCHK;
				end
				C_FHCHK: begin
					state_q <= (h_rd_q == '0) ? C_FICLR : C_FIRD;
				end
				C_FIRD: begin
					state_q <= C_FICHK;
				end
				C_FICHK: begin
					if (i_rd_q == '0) begin
						state_q <= C_FHREL;
					end else begin
						idx_q   <= idx_q + IXW'(1);
						freed_q <= freed_q + FCW'(1);
						ret_q   <= i_last ? C_FHREL : C_FIRD;
						state_q <= C_RWAIT;
					end
				end
				C_FHREL: begin
					idx_q   <= '0;
					freed_q <= freed_q + FCW'(1);
					ret_q   <= C_FICLR;
					state_q <= C_RWAIT;
				end
				C_FICLR: begin
					if (i_last) begin
						idx_q      <= '0;
						res_q      <= '{12'd0, fbm_pkg::ST_OK, 9'(freed_q)};
						res_pend_q <= 1'b1;
						state_q    <= C_IDLE;
					end else begin
						idx_q <= idx_q + IXW'(1);
					end
				end
				C_RWAIT: begin
					if (arsp.done) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_pend_q;
	assign res_word  = res_q;

	// never allocate and release at once
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		!(areq.alloc && areq.rel))
		else $error("allocate and release together");

	// requests only go to a ready allocator
	a_req_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(areq.alloc || areq.rel) |-> arsp.ready)
		else $error("request to busy allocator");

	// a pending word holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_pend_q && !res_ready) |=> (res_pend_q && $stable(res_q)))
		else $error("pending result word lost");

endmodule

@@ rtl/file_block_map_allocator.sv @@
// file_block_map_allocator: top level with configuration registers and the output
// word register; instantiates fbm_ctrl and fbm_alloc. Uses fbm_pkg.
`timescale 1ns / 1ps

// Maps (file slot, logical block) to a physical block through 12 direct pointers
// and one 256-entry indirect block per file, allocating from a free bitmap the
// lowest free block in [max(data_first,1), min(data_end, DISK_BLOCKS)). One
// command word is worked at a time; cmd_stall is high until its result word is
// handed to the output register. After reset a clearing pass wipes the pointer
// memories before the first word is taken. Each allocation scans the bitmap
// a word of 16 blocks at a time from the low end of the window. A free examines
// every direct pointer and the indirect entries up to the first empty one,
// releasing each block found and then the indirect block, if any, and then
// sweeps the indirect entries clear. DISK_BLOCKS must be a power of two.
module file_block_map_allocator #(
	parameter int FILES         = 128,
	parameter int DIRECT_PTRS   = 12,
	parameter int INDIRECT_PTRS = 256,
	parameter int DISK_BLOCKS   = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  fbm_pkg::cmd_word_t  cmd_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output fbm_pkg::rsp_word_t  rsp_word,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [12:0]         cfg_data
);

	localparam int PW = $clog2(DISK_BLOCKS);

	logic [11:0]           data_first_q;
	logic [12:0]           data_end_q;
	logic                  out_valid_q;
	fbm_pkg::rsp_word_t    out_q;
	logic                  res_valid;
	logic                  res_ready;
	fbm_pkg::rsp_word_t    res_word;
	fbm_pkg::alloc_req_t   areq;
	fbm_pkg::alloc_rsp_t   arsp;
	logic [PW-1:0]         ablk;
	logic [PW-1:0]         rel_blk;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_first_q <= 12'd9;
			data_end_q   <= 13'd4090;
		end else if (cfg_we) begin
			case (cfg_index)
				fbm_pkg::CFG_DATA_FIRST: data_first_q <= cfg_data[11:0];
				fbm_pkg::CFG_DATA_END:   data_end_q   <= cfg_data;
				default:                 data_end_q   <= data_end_q;
			endcase
		end
	end

	// output word register
	assign res_ready = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_word;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_q;

	fbm_ctrl #(
		.FILES         (FILES),
		.DIRECT_PTRS   (DIRECT_PTRS),
		.INDIRECT_PTRS (INDIRECT_PTRS),
		.DISK_BLOCKS   (DISK_BLOCKS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word),
		.areq      (areq),
		.arsp      (arsp),
		.ablk      (ablk),
		.rel_blk   (rel_blk)
	);

	fbm_alloc #(
		.DISK_BLOCKS (DISK_BLOCKS)
	) u_alloc (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_first (data_first_q),
		.data_end   (data_end_q),
		.req        (areq),
		.rel_blk    (rel_blk),
		.rsp        (arsp),
		.blk        (ablk)
	);

	// range errors carry no block and no count
	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == fbm_pkg::ST_RANGE) |->
		(out_q.physical_block == 12'd0 && out_q.freed_count == 9'd0))
		else $error("range error word carries data");

endmodule

@@ test/tb_top.sv @@
// tb_top: self-checking bench for file_block_map_allocator, with an in-bench
// block map and free bitmap model. Depends on fbm_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int NFILES   = 128;
	localparam int NDIRECT  = 12;
	localparam int NINDIR   = 256;
	localparam int NDISK    = 4096;
	localparam int IDLE_MAX = 200000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	fbm_pkg::cmd_word_t  cmd_word = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	fbm_pkg::rsp_word_t  rsp_word;
	logic                cfg_we = 1'b0;
	logic                cfg_index = 1'b0;
	logic [12:0]         cfg_data = '0;

	// model of the block's maps and window
	bit          used_map [NDISK];
	logic [11:0] direct_ptr [NFILES*NDIRECT];
	logic [11:0] indir_home [NFILES];
	logic [11:0] indir_ptr [NFILES*NINDIR];
	int          win_first;
	int          win_end;

	fbm_pkg::rsp_word_t expected_rsp[$];
	int        errors = 0;
	bit        calm = 1'b0;
	int        idle_cycles = 0;
	int        stall_left = 0;
	int        next_lb [NFILES];

	file_block_map_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_word(cmd_word),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// lowest free block in the window, 0 when none
	function automatic logic [11:0] take_free_block();
		int lo, hi;
		lo = (win_first == 0) ? 1 : win_first;
		hi = (win_end > NDISK) ? NDISK : win_end;
		for (int b = lo; b < hi; b++) begin
			if (!used_map[b]) begin
				used_map[b] = 1'b1;
				return b[11:0];
			end
		end
		return '0;
	endfunction

	function automatic fbm_pkg::rsp_word_t map_block(fbm_pkg::cmd_word_t w);
		fbm_pkg::rsp_word_t r;
		int s, lb, idx;
		bit have_table, is_direct;
		logic [11:0] cur, got;
		r = '0;
		s = int'(w.file_slot);
		lb = int'(w.logical_block);
		if (w.command == fbm_pkg::CMD_UNUSED) begin
			r.status = fbm_pkg::ST_RANGE;
		end else if (w.command == fbm_pkg::CMD_FREE) begin
			for (int i = 0; i < NDIRECT; i++) begin
				if (direct_ptr[s*NDIRECT+i] != 0) begin
					used_map[direct_ptr[s*NDIRECT+i]] = 1'b0;
					r.freed_count++;
				end
				direct_ptr[s*NDIRECT+i] = '0;
			end
			if (indir_home[s] != 0) begin
				for (int i = 0; i < NINDIR; i++) begin
					if (indir_ptr[s*NINDIR+i] == 0) break;
					used_map[indir_ptr[s*NINDIR+i]] = 1'b0;
					r.freed_count++;
				end
				used_map[indir_home[s]] = 1'b0;
				r.freed_count++;
				indir_home[s] = '0;
			end
			for (int i = 0; i < NINDIR; i++) indir_ptr[s*NINDIR+i] = '0;
		end else if (lb >= NDIRECT + NINDIR) begin
			r.status = fbm_pkg::ST_RANGE;
		end else begin
			have_table = 1'b1;
			is_direct = (lb < NDIRECT);
			idx = is_direct ? s*NDIRECT + lb : s*NINDIR + lb - NDIRECT;
			if (!is_direct && indir_home[s] == 0) begin
				if (w.command == fbm_pkg::CMD_WRITE) begin
					got = take_free_block();
					if (got == 0) have_table = 1'b0;
					else indir_home[s] = got;
				end else begin
					have_table = 1'b0;
				end
			end
			cur = is_direct ? direct_ptr[idx] : indir_ptr[idx];
			if (!have_table) begin
				r.status = (w.command == fbm_pkg::CMD_WRITE) ?
					fbm_pkg::ST_FULL : fbm_pkg::ST_UNMAPPED;
			end else if (cur != 0) begin
				r.physical_block = cur;
			end else if (w.command == fbm_pkg::CMD_WRITE) begin
				got = take_free_block();
				if (got == 0) begin
					r.status = fbm_pkg::ST_FULL;
				end else begin
					if (is_direct) direct_ptr[idx] = got;
					else indir_ptr[idx] = got;
					r.physical_block = got;
				end
			end else begin
				r.status = fbm_pkg::ST_UNMAPPED;
			end
		end
		return r;
	endfunction

	// send one command word, with an optional gap before it
	task automatic send_cmd(logic [1:0] cmd, int slot, int lb);
		fbm_pkg::cmd_word_t w;
		w.command = cmd;
		w.file_slot = slot[6:0];
		w.logical_block = lb[8:0];
		if (!calm && $urandom_range(0, 3) == 0) begin
			cmd_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		expected_rsp.push_back(map_block(w));
		cmd_valid = 1'b1;
		cmd_word = w;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
	endtask

	// register write once every result is back
	task automatic set_reg(logic idx, int value);
		cmd_valid = 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[12:0];
		if (idx == fbm_pkg::CFG_DATA_FIRST) win_first = value & 12'hFFF;
		else win_end = value & 13'h1FFF;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_directed();
		send_cmd(fbm_pkg::CMD_WRITE, 0, 0);
		send_cmd(fbm_pkg::CMD_READ, 0, 0);
		send_cmd(fbm_pkg::CMD_READ, 0, 1);
		send_cmd(fbm_pkg::CMD_READ, 0, 12);      // no indirect block yet
		send_cmd(fbm_pkg::CMD_WRITE, 0, 12);     // allocates indirect block and data
		send_cmd(fbm_pkg::CMD_WRITE, 0, 267);
		send_cmd(fbm_pkg::CMD_READ, 0, 267);
		send_cmd(fbm_pkg::CMD_WRITE, 0, 268);    // out of range
		send_cmd(fbm_pkg::CMD_READ, 0, 511);
		send_cmd(fbm_pkg::CMD_UNUSED, 127, 0);   // unused command
		send_cmd(fbm_pkg::CMD_FREE, 0, 0);       // stops at first empty indirect entry
		send_cmd(fbm_pkg::CMD_FREE, 1, 0);       // empty file
		send_cmd(fbm_pkg::CMD_WRITE, 127, 11);
		send_cmd(fbm_pkg::CMD_FREE, 127, 511);
	endtask

	task automatic test_window_edges();
		// empty window
		set_reg(fbm_pkg::CFG_DATA_FIRST, 0);
		set_reg(fbm_pkg::CFG_DATA_END, 0);
		send_cmd(fbm_pkg::CMD_WRITE, 3, 0);
		send_cmd(fbm_pkg::CMD_WRITE, 3, 100);
		// one block: indirect block fits, data block does not
		set_reg(fbm_pkg::CFG_DATA_FIRST, 4095);
		set_reg(fbm_pkg::CFG_DATA_END, 4096);
		send_cmd(fbm_pkg::CMD_WRITE, 5, 12);
		send_cmd(fbm_pkg::CMD_WRITE, 5, 12);
		send_cmd(fbm_pkg::CMD_READ, 5, 12);
		send_cmd(fbm_pkg::CMD_FREE, 5, 0);
		send_cmd(fbm_pkg::CMD_WRITE, 5, 0);
		send_cmd(fbm_pkg::CMD_FREE, 5, 0);
		// zero start never hands out block 0
		set_reg(fbm_pkg::CFG_DATA_FIRST, 0);
		set_reg(fbm_pkg::CFG_DATA_END, 4096);
		send_cmd(fbm_pkg::CMD_WRITE, 6, 3);
		send_cmd(fbm_pkg::CMD_READ, 6, 3);
		send_cmd(fbm_pkg::CMD_FREE, 6, 0);
	endtask

	// mostly growing files on a few slots, plus reads, frees and noise
	task automatic test_random(int count, int first, int last_blk);
		int slot, roll, lb;
		set_reg(fbm_pkg::CFG_DATA_FIRST, first);
		set_reg(fbm_pkg::CFG_DATA_END, last_blk);
		for (int n = 0; n < count; n++) begin
			calm = (n >= count - 80);
			slot = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 127);
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				send_cmd(fbm_pkg::CMD_WRITE, slot, next_lb[slot]);
				next_lb[slot] = (next_lb[slot] + 1) % (NDIRECT + NINDIR);
			end else if (roll < 65) begin
				send_cmd(fbm_pkg::CMD_WRITE, slot, $urandom_range(0, 267));
			end else if (roll < 85) begin
				send_cmd(fbm_pkg::CMD_READ, slot, $urandom_range(0, 267));
			end else if (roll < 90) begin
				send_cmd(fbm_pkg::CMD_FREE, slot, $urandom_range(0, 511));
				next_lb[slot] = 0;
			end else if (roll < 95) begin
				lb = $urandom_range(268, 511);
				send_cmd(($urandom_range(0, 1) == 0) ? fbm_pkg::CMD_WRITE : fbm_pkg::CMD_READ,
					slot, lb);
			end else begin
				send_cmd(fbm_pkg::CMD_UNUSED, slot, $urandom_range(0, 511));
			end
		end
		calm = 1'b0;
	endtask

	// result stall in random bursts
	always @(negedge clk) begin
		if (calm) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1) begin
				rsp_stall <= 1'b0;
			end
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(1, 6);
			rsp_stall  <= 1'b1;
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		fbm_pkg::rsp_word_t e;
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected word %h", $time, rsp_word);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp_word.physical_block !== e.physical_block) begin
					$display("%0t: physical_block expected %0d actual %0d",
						$time, e.physical_block, rsp_word.physical_block);
					errors++;
				end
				if (rsp_word.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, e.status, rsp_word.status);
					errors++;
				end
				if (rsp_word.freed_count !== e.freed_count) begin
					$display("%0t: freed_count expected %0d actual %0d",
						$time, e.freed_count, rsp_word.freed_count);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	initial begin
		foreach (used_map[i]) used_map[i] = 1'b0;
		foreach (direct_ptr[i]) direct_ptr[i] = '0;
		foreach (indir_home[i]) indir_home[i] = '0;
		foreach (indir_ptr[i]) indir_ptr[i] = '0;
		foreach (next_lb[i]) next_lb[i] = 0;
		win_first = 9;
		win_end = 4090;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_window_edges();
		test_random(330, 9, 4090);
		test_random(330, 2000, 2040);
		test_random(340, 0, 4096);

		cmd_valid = 1'b0;
		calm = 1'b1;
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/fbm_pkg.sv
rtl/fbm_alloc.sv
rtl/fbm_ctrl.sv
rtl/file_block_map_allocator.sv
test/tb_top.sv
